/* rtl/ljpf_pkg.sv */
// Shared constants and types of the Lennard-Jones pair force engine.
package ljpf_pkg;

  localparam logic [2:0] CFG_BOX_LENGTH    = 3'd0;
  localparam logic [2:0] CFG_CUTOFF_RADIUS = 3'd1;
  localparam logic [2:0] CFG_EPS_LOW       = 3'd2;
  localparam logic [2:0] CFG_EPS_HIGH      = 3'd3;
  localparam logic [2:0] CFG_SIGMA_LOW     = 3'd4;
  localparam logic [2:0] CFG_SIGMA_HIGH    = 3'd5;

  localparam int MAX_TYPES = 6;

  localparam logic [30:0] CUTOFF_RESET = 31'd167772160;
  localparam logic [63:0] MIN_RSQ      = 64'd28147;
  localparam logic [37:0] Q_CAP        = 38'h20_0000_0000;
  localparam logic [46:0] OUT_MAX      = 47'h7FFF_FFFF_FFFF;

  typedef logic [15:0] prm_t;
  typedef logic signed [47:0] res_t;

endpackage

/* rtl/lj_pair_force_energy.sv */
// Lennard-Jones pair force and energy engine, top level.
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | two positions, two atom types
//   out     | source    | out_valid/out_stall| force x/y/z, pair energy, in-range flag
//   cfg     | sink      | cfg_we             | cfg_index, cfg_wdata
//
// One pair per cycle unless a stalled result freezes the whole pipeline; in_stall
// follows it. The pipeline holds the 33-step wrap remainder, the 38-step s^2
// divider and the 47-step force divider. Synchronous reset clears the valid bits
// and the configuration registers, but loads the cutoff with its reset value.
module lj_pair_force_energy #(
  parameter int NUM_TYPES = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_first_x,
  input  logic signed [31:0]  in_first_y,
  input  logic signed [31:0]  in_first_z,
  input  logic signed [31:0]  in_second_x,
  input  logic signed [31:0]  in_second_y,
  input  logic signed [31:0]  in_second_z,
  input  logic [2:0]          in_first_type,
  input  logic [2:0]          in_second_type,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  out_force_x,
  output logic signed [47:0]  out_force_y,
  output logic signed [47:0]  out_force_z,
  output logic signed [47:0]  out_pair_energy,
  output logic                out_within_cutoff,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);

  localparam int VLAT     = 133;
  localparam int DL_V     = 33;
  localparam int DL_EPS1  = 17;
  localparam int DL_SIG2  = 34;
  localparam int DL_Q     = 2;
  localparam int DL_Q3    = 2;
  localparam int DL_K     = 46;
  localparam int DL_EPS2  = 48;
  localparam int DL_R2    = 10;
  localparam int DL_E     = 46;
  localparam int DL_GE    = 49;
  localparam int DL_SGN   = 98;
  localparam int DL_INR   = 95;
  localparam int SQ_STEPS = 16;

  // configuration
  logic [30:0] box_r;
  logic [30:0] cut_r;
  logic [63:0] epsl_r;
  logic [31:0] epsh_r;
  logic [63:0] sigl_r;
  logic [31:0] sigh_r;
  logic [61:0] cut2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r  <= '0;
      cut_r  <= ljpf_pkg::CUTOFF_RESET;
      epsl_r <= '0;
      epsh_r <= '0;
      sigl_r <= '0;
      sigh_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ljpf_pkg::CFG_BOX_LENGTH:    box_r  <= cfg_wdata[30:0];
        ljpf_pkg::CFG_CUTOFF_RADIUS: cut_r  <= cfg_wdata[30:0];
        ljpf_pkg::CFG_EPS_LOW:       epsl_r <= cfg_wdata;
        ljpf_pkg::CFG_EPS_HIGH:      epsh_r <= cfg_wdata[31:0];
        ljpf_pkg::CFG_SIGMA_LOW:     sigl_r <= cfg_wdata;
        ljpf_pkg::CFG_SIGMA_HIGH:    sigh_r <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cut2_r <= {31'd0, cut_r} * {31'd0, cut_r};
  end

  // flow control
  logic en;
  logic out_valid_r;
  logic vld_r [VLAT];

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VLAT; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < VLAT; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[VLAT-1];
    end
  end

  // separation and type lookup
  logic signed [32:0] dv_nxt [3];
  logic signed [32:0] s1_v_r [3];
  logic [2:0]         s1_ta_r;
  logic [2:0]         s1_tb_r;

  assign dv_nxt[0] = 33'(in_first_x) - 33'(in_second_x);
  assign dv_nxt[1] = 33'(in_first_y) - 33'(in_second_y);
  assign dv_nxt[2] = 33'(in_first_z) - 33'(in_second_z);

  logic [95:0] eps_all;
  logic [95:0] sig_all;
  logic        ok_a;
  logic        ok_b;
  logic [6:0]  off_a;
  logic [6:0]  off_b;

  assign eps_all = {epsh_r, epsl_r};
  assign sig_all = {sigh_r, sigl_r};
  assign ok_a = ({29'd0, s1_ta_r} < NUM_TYPES) && ({29'd0, s1_ta_r} < ljpf_pkg::MAX_TYPES);
  assign ok_b = ({29'd0, s1_tb_r} < NUM_TYPES) && ({29'd0, s1_tb_r} < ljpf_pkg::MAX_TYPES);
  assign off_a = ok_a ? {s1_ta_r, 4'd0} : 7'd0;
  assign off_b = ok_b ? {s1_tb_r, 4'd0} : 7'd0;

  ljpf_pkg::prm_t ei_r, ej_r, si_r, sj_r;
  logic [31:0]    eij_r;
  logic [16:0]    ssum_r;
  logic [33:0]    sig2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) s1_v_r[a] <= dv_nxt[a];
      s1_ta_r <= in_first_type;
      s1_tb_r <= in_second_type;
      ei_r    <= ok_a ? eps_all[off_a +: 16] : '0;
      si_r    <= ok_a ? sig_all[off_a +: 16] : '0;
      ej_r    <= ok_b ? eps_all[off_b +: 16] : '0;
      sj_r    <= ok_b ? sig_all[off_b +: 16] : '0;
      eij_r   <= {16'd0, ei_r} * {16'd0, ej_r};
      ssum_r  <= {1'b0, si_r} + {1'b0, sj_r};
      sig2_r  <= {17'd0, ssum_r} * {17'd0, ssum_r};
    end
  end

  // geometric-mean epsilon, one root bit per stage
  logic [15:0] sq_res_r   [SQ_STEPS];
  logic [31:0] sq_x_r     [SQ_STEPS];
  logic [15:0] sq_res_nxt [SQ_STEPS];
  logic [31:0] sq_x_nxt   [SQ_STEPS];

  always_comb begin
    logic [15:0] rin;
    logic [15:0] tv;
    logic [31:0] xin;
    for (int i = 0; i < SQ_STEPS; i++) begin
      if (i == 0) begin
        rin = '0;
        xin = eij_r;
      end else begin
        rin = sq_res_r[i-1];
        xin = sq_x_r[i-1];
      end
      tv = rin | (16'd1 << (SQ_STEPS - 1 - i));
      sq_res_nxt[i] = (({16'd0, tv} * {16'd0, tv}) <= xin) ? tv : rin;
      sq_x_nxt[i]   = xin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        sq_res_r[i] <= sq_res_nxt[i];
        sq_x_r[i]   <= sq_x_nxt[i];
      end
    end
  end

  // minimum image remainder
  logic [33:0]        mnum [3];
  logic [30:0]        mrem [3];
  logic [32:0]        mquo [3];
  logic [30:0]        mden [3];
  logic               movf [3];

  for (genvar a = 0; a < 3; a++) begin : g_mod
    assign mnum[a] = {1'b0, (s1_v_r[a] < 0) ? 33'(-s1_v_r[a]) : 33'(s1_v_r[a])};
    ljpf_div #(.NW(34), .QW(33), .DW(31)) u_mod (
      .clk(clk), .en(en), .num(mnum[a]), .den(box_r),
      .quo(mquo[a]), .rem(mrem[a]), .den_o(mden[a]), .ovf(movf[a])
    );
  end

  // delay lines
  logic signed [32:0] dl_v_r    [DL_V][3];
  ljpf_pkg::prm_t     dl_eps1_r [DL_EPS1];
  logic [33:0]        dl_sig2_r [DL_SIG2];
  logic [37:0]        dl_q_r    [DL_Q];
  logic [47:0]        dl_q3_r   [DL_Q3];
  logic [51:0]        dl_k_r    [DL_K][3];
  ljpf_pkg::prm_t     dl_eps2_r [DL_EPS2];
  logic [61:0]        dl_r2_r   [DL_R2];
  logic [46:0]        dl_e_r    [DL_E];
  logic [1:0]         dl_ge_r   [DL_GE];
  logic [2:0]         dl_sgn_r  [DL_SGN];
  logic               dl_inr_r  [DL_INR];

  logic signed [32:0] d_r [3];
  logic [51:0]        k_r [3];
  logic               inr_r;
  logic [37:0]        q_r;
  logic [79:0]        q3_w;
  logic [46:0]        esat_r;
  logic               gneg_r;
  logic               eneg_r;
  logic [61:0]        qden;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) dl_v_r[0][a] <= s1_v_r[a];
      for (int i = 1; i < DL_V; i++) dl_v_r[i] <= dl_v_r[i-1];
      dl_eps1_r[0] <= sq_res_r[SQ_STEPS-1];
      for (int i = 1; i < DL_EPS1; i++) dl_eps1_r[i] <= dl_eps1_r[i-1];
      dl_sig2_r[0] <= sig2_r;
      for (int i = 1; i < DL_SIG2; i++) dl_sig2_r[i] <= dl_sig2_r[i-1];
      dl_q_r[0] <= q_r;
      for (int i = 1; i < DL_Q; i++) dl_q_r[i] <= dl_q_r[i-1];
      dl_q3_r[0] <= q3_w[79:32];
      for (int i = 1; i < DL_Q3; i++) dl_q3_r[i] <= dl_q3_r[i-1];
      for (int a = 0; a < 3; a++) dl_k_r[0][a] <= k_r[a];
      for (int i = 1; i < DL_K; i++) dl_k_r[i] <= dl_k_r[i-1];
      dl_eps2_r[0] <= dl_eps1_r[DL_EPS1-1];
      for (int i = 1; i < DL_EPS2; i++) dl_eps2_r[i] <= dl_eps2_r[i-1];
      dl_r2_r[0] <= qden;
      for (int i = 1; i < DL_R2; i++) dl_r2_r[i] <= dl_r2_r[i-1];
      dl_e_r[0] <= esat_r;
      for (int i = 1; i < DL_E; i++) dl_e_r[i] <= dl_e_r[i-1];
      dl_ge_r[0] <= {gneg_r, eneg_r};
      for (int i = 1; i < DL_GE; i++) dl_ge_r[i] <= dl_ge_r[i-1];
      dl_sgn_r[0] <= {d_r[2][32], d_r[1][32], d_r[0][32]};
      for (int i = 1; i < DL_SGN; i++) dl_sgn_r[i] <= dl_sgn_r[i-1];
      dl_inr_r[0] <= inr_r;
      for (int i = 1; i < DL_INR; i++) dl_inr_r[i] <= dl_inr_r[i-1];
    end
  end

  // wrap, magnitudes, squared distance
  logic signed [32:0] d_nxt [3];

  always_comb begin
    logic [30:0]        mv;
    logic signed [32:0] wv;
    logic signed [32:0] vv;
    for (int a = 0; a < 3; a++) begin
      vv = dl_v_r[DL_V-1][a];
      mv = ((vv < 0) && (mrem[a] != '0)) ? (box_r - mrem[a]) : mrem[a];
      if ({mv, 1'b0} >= {1'b0, box_r}) begin
        wv = $signed({2'b00, mv}) - $signed({2'b00, box_r});
      end else begin
        wv = $signed({2'b00, mv});
      end
      d_nxt[a] = (box_r != '0) ? wv : vv;
    end
  end

  logic [32:0] mag_r [3];
  logic [2:0]  far_r;
  logic        far2_r;
  logic [61:0] sq_r  [3];
  logic [46:0] me_r  [3];
  logic [63:0] r2_r;
  logic [63:0] r2_sum;

  assign r2_sum = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        d_r[a]   <= d_nxt[a];
        mag_r[a] <= (d_r[a] < 0) ? 33'(-d_r[a]) : 33'(d_r[a]);
        far_r[a] <= ((d_r[a] < 0) ? 33'(-d_r[a]) : 33'(d_r[a])) >= {2'b00, cut_r};
        sq_r[a]  <= {31'd0, mag_r[a][30:0]} * {31'd0, mag_r[a][30:0]};
        me_r[a]  <= {16'd0, mag_r[a][30:0]} * {31'd0, dl_eps1_r[DL_EPS1-1]};
        k_r[a]   <= ({5'd0, me_r[a]} << 4) + ({5'd0, me_r[a]} << 3);
      end
      far2_r <= |far_r;
      r2_r   <= r2_sum;
      inr_r  <= !far2_r && (r2_sum > ljpf_pkg::MIN_RSQ) && (r2_sum < {2'b00, cut2_r});
    end
  end

  // s^2 = sigma^2 / r^2
  logic [37:0] qquo;
  logic [61:0] qrem;
  logic        qovf;

  ljpf_div #(.NW(88), .QW(38), .DW(62)) u_qdiv (
    .clk(clk), .en(en), .num({dl_sig2_r[DL_SIG2-1], 54'd0}), .den(r2_r[61:0]),
    .quo(qquo), .rem(qrem), .den_o(qden), .ovf(qovf)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= (qovf || (qquo > ljpf_pkg::Q_CAP)) ? ljpf_pkg::Q_CAP : qquo;
    end
  end

  logic [75:0] q2_w;
  logic [81:0] q3p_w;
  logic [95:0] q6_w;

  ljpf_mul #(.AW(38), .BW(38)) u_mq2 (.clk(clk), .en(en), .a(q_r), .b(q_r), .p(q2_w));
  ljpf_mul #(.AW(44), .BW(38)) u_mq3 (
    .clk(clk), .en(en), .a(q2_w[75:32]), .b(dl_q_r[DL_Q-1]), .p(q3p_w)
  );
  assign q3_w = q3p_w[79:0];
  ljpf_mul #(.AW(48), .BW(48)) u_mq6 (
    .clk(clk), .en(en), .a(q3_w[79:32]), .b(q3_w[79:32]), .p(q6_w)
  );

  logic [62:0] q6;
  logic [63:0] twoq6;
  logic [63:0] q3x;
  logic [63:0] gmag_r;
  logic [62:0] dmag_r;

  assign q6    = q6_w[94:32];
  assign twoq6 = {q6, 1'b0};
  assign q3x   = {16'd0, dl_q3_r[DL_Q3-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      gneg_r <= twoq6 < q3x;
      gmag_r <= (twoq6 < q3x) ? (q3x - twoq6) : (twoq6 - q3x);
      eneg_r <= {1'b0, q6} < q3x;
      dmag_r <= ({1'b0, q6} < q3x) ? 63'(q3x - {1'b0, q6}) : 63'({1'b0, q6} - q3x);
    end
  end

  // force and energy
  logic [115:0] fnum [3];
  logic [46:0]  fquo [3];
  logic [61:0]  frem [3];
  logic [61:0]  fden [3];
  logic         fovf [3];
  logic [95:0]  eprod;

  for (genvar a = 0; a < 3; a++) begin : g_force
    ljpf_mul #(.AW(64), .BW(52)) u_mf (
      .clk(clk), .en(en), .a(gmag_r), .b(dl_k_r[DL_K-1][a]), .p(fnum[a])
    );
    ljpf_div #(.NW(116), .QW(47), .DW(62)) u_fdiv (
      .clk(clk), .en(en), .num(fnum[a]), .den(dl_r2_r[DL_R2-1]),
      .quo(fquo[a]), .rem(frem[a]), .den_o(fden[a]), .ovf(fovf[a])
    );
  end

  ljpf_mul #(.AW(63), .BW(33)) u_me (
    .clk(clk), .en(en), .a(dmag_r), .b({17'd0, dl_eps2_r[DL_EPS2-1]}), .p(eprod)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      esat_r <= (eprod[95:22] > {27'd0, ljpf_pkg::OUT_MAX}) ? ljpf_pkg::OUT_MAX
                                                            : eprod[68:22];
    end
  end

  // result beat
  ljpf_pkg::res_t fo_nxt [3];
  ljpf_pkg::res_t eo_nxt;
  logic           inr_o;

  assign inr_o = dl_inr_r[DL_INR-1];

  always_comb begin
    logic [46:0] fm;
    logic        ng;
    for (int a = 0; a < 3; a++) begin
      fm = fovf[a] ? ljpf_pkg::OUT_MAX : fquo[a];
      ng = dl_ge_r[DL_GE-1][1] ^ dl_sgn_r[DL_SGN-1][a];
      if (!inr_o) begin
        fo_nxt[a] = '0;
      end else if (ng) begin
        fo_nxt[a] = -$signed({1'b0, fm});
      end else begin
        fo_nxt[a] = $signed({1'b0, fm});
      end
    end
    if (!inr_o) begin
      eo_nxt = '0;
    end else if (dl_ge_r[DL_GE-1][0]) begin
      eo_nxt = -$signed({1'b0, dl_e_r[DL_E-1]});
    end else begin
      eo_nxt = $signed({1'b0, dl_e_r[DL_E-1]});
    end
  end

  ljpf_pkg::res_t fx_r, fy_r, fz_r, en_r;
  logic           win_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r  <= fo_nxt[0];
      fy_r  <= fo_nxt[1];
      fz_r  <= fo_nxt[2];
      en_r  <= eo_nxt;
      win_r <= inr_o;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_force_x       = fx_r;
  assign out_force_y       = fy_r;
  assign out_force_z       = fz_r;
  assign out_pair_energy   = en_r;
  assign out_within_cutoff = win_r;

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_within_cutoff |->
      out_force_x == 0 && out_force_y == 0 && out_force_z == 0 && out_pair_energy == 0)
    else $error("out-of-range beat carries nonzero values");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_cut_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_within_cutoff |-> cut_r != '0)
    else $error("in-range beat with zero cutoff");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held without a waiting result");

endmodule

/* rtl/ljpf_mul.sv */
// Two-stage multiplier built from partial products of at most 32 by 32 bits.
module ljpf_mul #(
  parameter int AW = 48,
  parameter int BW = 48
) (
  input  logic              clk,
  input  logic              en,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic [AW+BW-1:0]  p
);

  localparam int LW  = 32;
  localparam int AHW = AW - LW;
  localparam int BHW = BW - LW;
  localparam int PW  = AW + BW;

  logic [2*LW-1:0]      ll_r;
  logic [LW+BHW-1:0]    lh_r;
  logic [AHW+LW-1:0]    hl_r;
  logic [AHW+BHW-1:0]   hh_r;
  logic [PW-1:0]        p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= {{LW{1'b0}}, a[LW-1:0]} * {{LW{1'b0}}, b[LW-1:0]};
      lh_r <= {{BHW{1'b0}}, a[LW-1:0]} * {{LW{1'b0}}, b[BW-1:LW]};
      hl_r <= {{LW{1'b0}}, a[AW-1:LW]} * {{AHW{1'b0}}, b[LW-1:0]};
      hh_r <= {{BHW{1'b0}}, a[AW-1:LW]} * {{AHW{1'b0}}, b[BW-1:LW]};
      p_r  <= PW'(ll_r) + (PW'(lh_r) << LW) + (PW'(hl_r) << LW) + (PW'(hh_r) << (2 * LW));
    end
  end

  assign p = p_r;

endmodule

/* rtl/ljpf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ljpf_div #(
  parameter int NW = 88,
  parameter int QW = 38,
  parameter int DW = 62
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] den_o,
  output logic          ovf
);

  localparam int HW = NW - QW;

  logic [DW-1:0] rem_r   [QW];
  logic [QW-1:0] low_r   [QW];
  logic [QW-1:0] quo_r   [QW];
  logic [DW-1:0] den_r   [QW];
  logic          ovf_r   [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];
  logic [DW-1:0] den_nxt [QW];
  logic          ovf_nxt [QW];

  logic [HW-1:0] num_hi;
  logic          ovf0;

  assign num_hi = num[NW-1:QW];
  assign ovf0   = (num_hi >= den);

  always_comb begin
    logic [DW:0]   tr;
    logic [DW-1:0] prem;
    logic [DW-1:0] pden;
    logic [QW-1:0] plow;
    logic [QW-1:0] pquo;
    logic          povf;
    logic          ge;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        prem = ovf0 ? '0 : DW'(num_hi);
        plow = num[QW-1:0];
        pquo = '0;
        pden = den;
        povf = ovf0;
      end else begin
        prem = rem_r[s-1];
        plow = low_r[s-1];
        pquo = quo_r[s-1];
        pden = den_r[s-1];
        povf = ovf_r[s-1];
      end
      tr = {prem, plow[QW-1]};
      ge = (tr >= {1'b0, pden});
      rem_nxt[s] = ge ? DW'(tr - {1'b0, pden}) : tr[DW-1:0];
      low_nxt[s] = plow << 1;
      quo_nxt[s] = {pquo[QW-2:0], ge};
      den_nxt[s] = pden;
      ovf_nxt[s] = povf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s] <= rem_nxt[s];
        low_r[s] <= low_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= den_nxt[s];
        ovf_r[s] <= ovf_nxt[s];
      end
    end
  end

  assign quo   = quo_r[QW-1];
  assign rem   = rem_r[QW-1];
  assign den_o = den_r[QW-1];
  assign ovf   = ovf_r[QW-1];

endmodule

/* test/tb_lj_pair_force_energy.sv */
// Self-checking testbench for the Lennard-Jones pair force and energy engine.
module tb_lj_pair_force_energy;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
    logic [2:0] ft, st;
  } pair_t;

  typedef struct {
    ljpf_pkg::res_t fx, fy, fz, en;
    logic inr;
  } lj_res_t;

  class lj_scoreboard;
    logic [63:0] regs[6];
    lj_res_t pending[$];
    int errors;
    int in_range_seen;

    function void reset_regs();
      foreach (regs[i]) regs[i] = '0;
      regs[ljpf_pkg::CFG_CUTOFF_RADIUS] = 64'(ljpf_pkg::CUTOFF_RESET);
      errors = 0;
      in_range_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        ljpf_pkg::CFG_BOX_LENGTH, ljpf_pkg::CFG_CUTOFF_RADIUS:
          regs[idx] = val & 64'h7FFF_FFFF;
        ljpf_pkg::CFG_EPS_HIGH, ljpf_pkg::CFG_SIGMA_HIGH:
          regs[idx] = val & 64'hFFFF_FFFF;
        ljpf_pkg::CFG_EPS_LOW, ljpf_pkg::CFG_SIGMA_LOW:
          regs[idx] = val;
        default: ;
      endcase
    endfunction

    function void type_prm(logic [2:0] t, output logic [63:0] e, output logic [63:0] s);
      e = 0;
      s = 0;
      if (t < ljpf_pkg::MAX_TYPES) begin
        if (t < 4) begin
          e = (regs[ljpf_pkg::CFG_EPS_LOW] >> (16 * t)) & 64'hFFFF;
          s = (regs[ljpf_pkg::CFG_SIGMA_LOW] >> (16 * t)) & 64'hFFFF;
        end else begin
          e = (regs[ljpf_pkg::CFG_EPS_HIGH] >> (16 * (t - 4))) & 64'hFFFF;
          s = (regs[ljpf_pkg::CFG_SIGMA_HIGH] >> (16 * (t - 4))) & 64'hFFFF;
        end
      end
    endfunction

    function logic [63:0] sat(logic [127:0] x, logic [63:0] cap);
      return (x > 128'(cap)) ? cap : x[63:0];
    endfunction

    function ljpf_pkg::res_t signed_mag(logic [63:0] m, bit neg);
      return neg ? ljpf_pkg::res_t'(-m[47:0]) : ljpf_pkg::res_t'(m[47:0]);
    endfunction

    function lj_res_t lj_predict(pair_t p);
      lj_res_t r;
      longint dv[3];
      longint v, m, l;
      logic [63:0] mag[3];
      logic [63:0] r2, cut, ei, ej, si, sj, prod, eps, t, s, sig2;
      logic [63:0] q, q2, q3, q6, twoq6, gmag, dmag, k;
      bit inr, gneg, eneg;
      r = '{default: '0};
      dv[0] = longint'(p.fx) - longint'(p.sx);
      dv[1] = longint'(p.fy) - longint'(p.sy);
      dv[2] = longint'(p.fz) - longint'(p.sz);
      cut = regs[ljpf_pkg::CFG_CUTOFF_RADIUS];
      l = longint'(regs[ljpf_pkg::CFG_BOX_LENGTH]);
      inr = 1;
      r2 = 0;
      for (int a = 0; a < 3; a++) begin
        v = dv[a];
        if (l != 0) begin
          m = v % l;
          if (m < 0) m += l;
          if (2 * m >= l) m -= l;
          v = m;
        end
        dv[a] = v;
        mag[a] = (v < 0) ? 64'(-v) : 64'(v);
        if (mag[a] >= cut) inr = 0;
      end
      if (inr) begin
        for (int a = 0; a < 3; a++) r2 += mag[a] * mag[a];
        inr = (r2 > ljpf_pkg::MIN_RSQ) && (r2 < cut * cut);
      end
      if (!inr) return r;
      r.inr = 1;
      type_prm(p.ft, ei, si);
      type_prm(p.st, ej, sj);
      prod = ei * ej;
      eps = 0;
      for (int b = 15; b >= 0; b--) begin
        t = eps | (64'd1 << b);
        if (t * t <= prod) eps = t;
      end
      s = si + sj;
      sig2 = s * s;
      q = sat((128'(sig2) << 54) / 128'(r2), 64'(ljpf_pkg::Q_CAP));
      q2 = sat((128'(q) * 128'(q)) >> 32, '1);
      q3 = sat((128'(q2) * 128'(q)) >> 32, '1);
      q6 = sat((128'(q3) * 128'(q3)) >> 32, '1);
      twoq6 = q6 << 1;
      gneg = twoq6 < q3;
      gmag = gneg ? q3 - twoq6 : twoq6 - q3;
      for (int a = 0; a < 3; a++) begin
        k = mag[a] * 64'd24 * eps;
        t = sat((128'(gmag) * 128'(k)) / 128'(r2), 64'(ljpf_pkg::OUT_MAX));
        case (a)
          0: r.fx = signed_mag(t, gneg != (dv[a] < 0));
          1: r.fy = signed_mag(t, gneg != (dv[a] < 0));
          default: r.fz = signed_mag(t, gneg != (dv[a] < 0));
        endcase
      end
      eneg = q6 < q3;
      dmag = eneg ? q3 - q6 : q6 - q3;
      r.en = signed_mag(sat((128'(eps) * 128'(dmag)) >> 22, 64'(ljpf_pkg::OUT_MAX)), eneg);
      return r;
    endfunction

    function void note_pair(pair_t p);
      pending.push_back(lj_predict(p));
    endfunction

    function void field(string name, logic [47:0] e, logic [47:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check_result(lj_res_t got);
      lj_res_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual force %h %h %h energy %h",
                 $time, got.fx, got.fy, got.fz, got.en);
        return;
      end
      e = pending.pop_front();
      if (e.inr) in_range_seen++;
      field("force_x", e.fx, got.fx);
      field("force_y", e.fy, got.fy);
      field("force_z", e.fz, got.fz);
      field("pair_energy", e.en, got.en);
      field("within_cutoff", 48'(e.inr), 48'(got.inr));
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_first_x = 0, in_first_y = 0, in_first_z = 0;
  logic signed [31:0] in_second_x = 0, in_second_y = 0, in_second_z = 0;
  logic [2:0] in_first_type = 0, in_second_type = 0;
  logic out_valid;
  logic out_stall = 0;
  ljpf_pkg::res_t out_force_x, out_force_y, out_force_z, out_pair_energy;
  logic out_within_cutoff;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [63:0] cfg_wdata = 0;

  lj_scoreboard sb;
  int tx_pct = 0, rx_pct = 0;
  logic hold_req = 0;
  int hold_left = 0;
  int beats_in = 0;

  lj_pair_force_energy u_top (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    #2ms;
    $display("tb_lj_pair_force_energy: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_pair('{in_first_x, in_first_y, in_first_z, in_second_x, in_second_y,
                     in_second_z, in_first_type, in_second_type});
      beats_in++;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_force_x, out_force_y, out_force_z, out_pair_energy,
                        out_within_cutoff});
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) hold_left = 400;
      if (hold_left > 0) begin
        out_stall <= 1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  task automatic send_pair(pair_t p);
    in_first_x <= p.fx;
    in_first_y <= p.fy;
    in_first_z <= p.fz;
    in_second_x <= p.sx;
    in_second_y <= p.sy;
    in_second_z <= p.sz;
    in_first_type <= p.ft;
    in_second_type <= p.st;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_regs(logic [63:0] box, logic [63:0] cut, logic [63:0] el,
                           logic [63:0] eh, logic [63:0] sl, logic [63:0] sh);
    logic [63:0] vals[6];
    vals = '{box, cut, el, eh, sl, sh};
    drain();
    repeat (140) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_index <= 3'd7;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] prm_set(int lo, int hi);
    logic [63:0] v;
    for (int i = 0; i < 4; i++) v[16*i +: 16] = 16'($urandom_range(hi, lo));
    return v;
  endfunction

  function automatic pair_t mk(longint a, longint b, longint c, longint dx, longint dy,
                               longint dz, int ft, int st);
    pair_t p;
    p.fx = 32'(a);
    p.fy = 32'(b);
    p.fz = 32'(c);
    p.sx = 32'(a - dx);
    p.sy = 32'(b - dy);
    p.sz = 32'(c - dz);
    p.ft = 3'(ft);
    p.st = 3'(st);
    return p;
  endfunction

  function automatic longint rnd_delta();
    return longint'($signed($urandom)) >>> $urandom_range(31, 4);
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    longint box, img;
    int kind, tmax;
    kind = $urandom_range(99);
    tmax = ($urandom_range(9) == 0) ? 7 : 5;
    if (kind < 15) begin
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            3'($urandom), 3'($urandom)};
    end else begin
      box = longint'(sb.regs[ljpf_pkg::CFG_BOX_LENGTH]);
      img = (box != 0 && $urandom_range(3) == 0) ? box * $urandom_range(3) : 0;
      p = mk(longint'($signed($urandom)), longint'($signed($urandom)),
             longint'($signed($urandom)), rnd_delta() + img, rnd_delta(), rnd_delta(),
             $urandom_range(tmax), $urandom_range(tmax));
    end
    return p;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_pair(rnd_pair());
  endtask

  localparam longint ANG = 64'd1 << 24;

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // register defaults: no parameters yet, only geometry matters
    tx_pct = 27;
    rx_pct = 56;
    send_pair(mk(0, 0, 0, 3 * ANG, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 0, 0, 0, 1, 2));
    send_pair(mk(5, 5, 5, 10 * ANG, 0, 0, 3, 3));
    send_pair(mk(-1, 0, 0, 4 * ANG, -4 * ANG, 0, 5, 4));
    run_random(40);

    load_regs(0, 10 * ANG, prm_set(8000, 20000), prm_set(8000, 20000),
              prm_set(12000, 15000), prm_set(12000, 15000));
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 1));
    send_pair(mk(0, 0, 0, 100, 100, 0, 0, 1));
    send_pair(mk(0, 0, 0, 168, 0, 0, 2, 2));
    send_pair(mk(0, 0, 0, 1 << 12, 0, 0, 3, 4));
    send_pair(mk(0, 0, 0, -(1 << 20), 0, 0, 5, 5));
    send_pair(mk(0, 0, 0, 10 * ANG, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 10 * ANG - 1, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 6 * ANG, 6 * ANG, 6 * ANG, 1, 1));
    send_pair(mk(0, 0, 0, 4 * ANG, -4 * ANG, 4 * ANG, 1, 2));
    send_pair(mk(7, 7, 7, 3 * ANG, -ANG, ANG / 2, 6, 0));
    send_pair(mk(7, 7, 7, 3 * ANG, -ANG, ANG / 2, 2, 7));
    send_pair(mk(-(64'sd1 <<< 31), 0, 0, -(64'sd1 <<< 31) + 1, 0, 0, 0, 0));
    send_pair(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -(64'sd1 <<< 31), 2 * ANG, ANG, -ANG, 4, 5));
    send_pair(mk(0, 0, 0, 3 * ANG + 12345, 2 * ANG, 0, 3, 1));
    run_random(330);

    tx_pct = 56;
    rx_pct = 27;
    load_regs(20 * ANG, 9 * ANG, rnd64(), rnd64(), rnd64(), rnd64());
    send_pair(mk(0, 0, 0, 19 * ANG, -19 * ANG, 10 * ANG, 0, 1));
    send_pair(mk(32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF - (-(64'sd1 <<< 31)), 0, 0, 2, 3));
    run_random(150);
    in_valid <= 0;
    hold_req <= 1;
    @(posedge clk);
    hold_req <= 0;
    run_random(200);

    tx_pct = 0;
    rx_pct = 0;
    load_regs(64'h7FFF_FFFF, 64'h7FFF_FFFF, '1, '1, '1, '1);
    send_pair(mk(-(64'sd1 <<< 31), -(64'sd1 <<< 31), 0,
                 -(64'sd1 <<< 31) - 32'sh7FFF_FFFF, 0, ANG, 5, 5));
    send_pair(mk(0, 0, 0, ANG / 16, 0, 0, 5, 5));
    run_random(150);
    drain();
    run_random(150);

    tx_pct = 27;
    rx_pct = 56;
    load_regs(1, 0, rnd64(), rnd64(), rnd64(), rnd64());
    run_random(60);
    load_regs(0, 0, rnd64(), rnd64(), rnd64(), rnd64());
    run_random(40);

    tx_pct = 0;
    rx_pct = 0;
    load_regs($urandom_range(2000, 40) * ANG / 4, $urandom_range(40, 4) * ANG / 4,
              prm_set(0, 65535), rnd64(), prm_set(4000, 20000), rnd64());
    run_random(120);

    drain();
    repeat (200) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    end
    $display("Run covered %0d pair beats, %0d of them in range, across seven register sets",
             beats_in, sb.in_range_seen);
    $display("with wrap on and off, zero and maximum cutoff, and receiver hold-off.");
    if (sb.errors == 0) begin
      $display("tb_lj_pair_force_energy: done, clean");
    end else begin
      $display("tb_lj_pair_force_energy: done, errors");
    end
    $finish;
  end
endmodule
